@@ sv/ats_pkg.sv @@
// ats_pkg: shared types, codes and helpers for the aging thread scheduler
`default_nettype none
package ats_pkg;

   localparam int SLOTS  = 4;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [7:0] SLEEP_MARK = 8'hFE;
   localparam logic [6:0] AGE_MAX    = 7'd127;

   localparam logic [7:0] TICK_DIVIDE_RST   = 8'd4;
   localparam logic [6:0] WAKE_PRIORITY_RST = 7'd9;
   localparam logic [7:0] TIME_RST          = 8'd1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIVIDE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_PRIORITY = 2'd1;

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_DELAY  = 3'd2;
   localparam logic [2:0] MODE_YIELD  = 3'd3;
   localparam logic [2:0] MODE_EXIT   = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_IDLE   = 2'd1;
   localparam logic [1:0] STATUS_NOFREE = 2'd2;

   localparam logic [1:0] ALU_TICK   = 2'd0;
   localparam logic [1:0] ALU_CREATE = 2'd1;
   localparam logic [1:0] ALU_READY  = 2'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0] thread;
      logic [1:0] status;
      logic [7:0] time_now;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic       is_run;
      logic       wake_hit;
      logic [6:0] wake_prio;
      logic [6:0] top;
   } alu_ctl_type;

   typedef struct packed {
      logic [7:0] new_prio;
      logic       hit;
   } alu_res_type;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

   function automatic logic is_ready(input logic [7:0] p);
      return (p != 8'd0) && (p[7] == 1'b0);
   endfunction

endpackage
`default_nettype wire

@@ sv/ats_slot_alu.sv @@
// ats_slot_alu: shared per-slot update and compare unit
`default_nettype none
module ats_slot_alu
   import ats_pkg::*;
(
   input  wire logic [7:0]  prio,
   input  wire alu_ctl_type ctl,
   output alu_res_type      res
);

   logic [6:0] wp;
   logic [7:0] aged;

   always_comb begin
      wp = (ctl.wake_prio == 7'd0) ? 7'd1 : ctl.wake_prio;
      aged = prio;
      if (is_ready(prio)) begin
         if (ctl.is_run) begin
            aged = 8'd1;
         end else if (prio[6:0] != AGE_MAX) begin
            aged = prio + 8'd1;
         end
      end else if ((prio == SLEEP_MARK) && ctl.wake_hit) begin
         aged = {1'b0, wp};
      end

      res = '0;
      case (ctl.op)
         ALU_TICK: begin
            res.new_prio = aged;
            res.hit = is_ready(aged) && (aged[6:0] > ctl.top);
         end
         ALU_CREATE: begin
            res.new_prio = 8'd1;
            res.hit = (prio == 8'd0);
         end
         ALU_READY: begin
            res.new_prio = prio;
            res.hit = is_ready(prio);
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ sv/aging_thread_scheduler_core.sv @@
// aging_thread_scheduler_core: slot scheduler with ageing, sleep and round-robin hand-over
//
//   port group   dir   handshake             payload
//   req_         in    req_valid/req_stall   req_type  (mode, delay_ticks)
//   rsp_         out   rsp_valid/rsp_stall   rsp_type  (thread, status, time_now)
//   csr_         in    csr_valid/csr_ready   csr_index, csr_data
//
// one item is scanned slot by slot through a single update/compare unit
// tick updates slots 1 to SLOTS-1, create and yield stop at the first hit, delay/exit
// mark the running slot, then scan; unused modes skip to done, which waits out rsp_ stall
// req_stall is high from acceptance until the result is loaded into the output register
// reset is synchronous; all slots free, time at one, no clearing pass
`default_nettype none
module aging_thread_scheduler_core
   import ats_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TICK   = 3'd1;
   localparam logic [2:0] ST_CREATE = 3'd2;
   localparam logic [2:0] ST_MARK   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] run_ff, run_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [6:0]        top_ff, top_in;
   logic [7:0]        presc_ff, presc_in;
   logic [7:0]        time_ff, time_in;
   logic [SLOT_W-1:0] res_thread_ff, res_thread_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [7:0]        tick_div_ff;
   logic [6:0]        wake_prio_ff;

   logic [7:0] prio_ff [SLOTS];
   logic [7:0] wake_ff [SLOTS];

   logic              prio_we;
   logic [7:0]        prio_wdata;
   logic              wake_we;
   logic [7:0]        wake_wdata;
   logic [7:0]        presc_nxt;
   logic [SLOT_W-1:0] pick;
   logic              rsp_free;

   alu_ctl_type alu_ctl;
   alu_res_type alu_res;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      alu_ctl.op        = ALU_READY;
      if (state_ff == ST_TICK) begin
         alu_ctl.op = ALU_TICK;
      end else if (state_ff == ST_CREATE) begin
         alu_ctl.op = ALU_CREATE;
      end
      alu_ctl.is_run    = (idx_ff == run_ff);
      alu_ctl.wake_hit  = (wake_ff[idx_ff] == time_ff);
      alu_ctl.wake_prio = wake_prio_ff;
      alu_ctl.top       = top_ff;
   end

   ats_slot_alu u_alu (
      .prio (prio_ff[idx_ff]),
      .ctl  (alu_ctl),
      .res  (alu_res)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      run_in        = run_ff;
      best_in       = best_ff;
      top_in        = top_ff;
      presc_in      = presc_ff;
      time_in       = time_ff;
      res_thread_in = res_thread_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      prio_we       = 1'b0;
      prio_wdata    = alu_res.new_prio;
      wake_we       = 1'b0;
      wake_wdata    = time_ff + req_ff.delay_ticks;
      presc_nxt     = (presc_ff == tick_div_ff) ? 8'd0 : presc_ff + 8'd1;
      pick          = alu_res.hit ? idx_ff : best_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               top_in  = '0;
               best_in = '0;
               case (req_data.mode)
                  MODE_TICK: begin
                     presc_in = presc_nxt;
                     if (presc_nxt == 8'd0) begin
                        time_in = time_ff + 8'd1;
                     end
                     idx_in   = SLOT_W'(1);
                     state_in = ST_TICK;
                  end
                  MODE_CREATE: begin
                     idx_in   = '0;
                     state_in = ST_CREATE;
                  end
                  MODE_DELAY, MODE_EXIT: begin
                     idx_in   = run_ff;
                     state_in = ST_MARK;
                  end
                  MODE_YIELD: begin
                     idx_in   = slot_next(run_ff);
                     state_in = ST_SCAN;
                  end
                  default: begin
                     res_thread_in = run_ff;
                     res_status_in = STATUS_OK;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            prio_we = 1'b1;
            if (alu_res.hit) begin
               top_in  = alu_res.new_prio[6:0];
               best_in = idx_ff;
            end
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               run_in        = pick;
               res_thread_in = pick;
               res_status_in = (pick == '0) ? STATUS_IDLE : STATUS_OK;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_CREATE: begin
            if (alu_res.hit) begin
               prio_we       = 1'b1;
               res_thread_in = idx_ff;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               res_thread_in = '0;
               res_status_in = STATUS_NOFREE;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_MARK: begin
            prio_we = 1'b1;
            if (req_ff.mode == MODE_DELAY) begin
               prio_wdata = SLEEP_MARK;
               wake_we    = 1'b1;
            end else begin
               prio_wdata = 8'd0;
            end
            idx_in   = slot_next(idx_ff);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (alu_res.hit) begin
               run_in        = idx_ff;
               res_thread_in = idx_ff;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end else if (idx_ff == run_ff) begin
               run_in        = '0;
               res_thread_in = '0;
               res_status_in = STATUS_IDLE;
               state_in      = ST_DONE;
            end else begin
               idx_in = slot_next(idx_ff);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.thread   = 2'(res_thread_ff);
               rsp_data_in.status   = res_status_ff;
               rsp_data_in.time_now = time_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= '0;
         presc_ff     <= 8'd0;
         time_ff      <= TIME_RST;
         rsp_valid_ff <= 1'b0;
         tick_div_ff  <= TICK_DIVIDE_RST;
         wake_prio_ff <= WAKE_PRIORITY_RST;
         for (int i = 0; i < SLOTS; i++) begin
            prio_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         presc_ff     <= presc_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICK_DIVIDE) begin
               tick_div_ff <= csr_data;
            end else if (csr_index == CSR_WAKE_PRIORITY) begin
               wake_prio_ff <= csr_data[6:0];
            end
         end
         if (prio_we) begin
            prio_ff[idx_ff] <= prio_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      top_ff        <= top_in;
      res_thread_ff <= res_thread_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      if (wake_we) begin
         wake_ff[idx_ff] <= wake_wdata;
      end
   end

   // an accepted item keeps the input side stalled on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after item accepted");

   // finishing state with a free output always hands over a result
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not delivered from done state");

   // idle status always reports slot zero
   a_idle_thread: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_IDLE) |-> (rsp_data.thread == 2'd0))
      else $error("idle result with non-zero thread");

   // status code three never appears
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != 2'd3))
      else $error("illegal status code");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking bench for the aging thread scheduler core, with csr phases and random idling
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ats_pkg::*;

   localparam int DRAIN_CYCLES = 12;
   localparam int TIMEOUT_NS   = 1_000_000;

   localparam logic [2:0]           MODE_SPARE_LO = MODE_EXIT + 3'd1;
   localparam logic [2:0]           MODE_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_data  = '0;

   req_type event_queue[$];
   rsp_type predicted_rsp[$];
   int      send_gap_pct = 0;
   int      rsp_hold_pct = 0;
   int      errors       = 0;

   logic [7:0]        slot_prio [SLOTS];
   logic [7:0]        wake_at   [SLOTS];
   logic [SLOT_W-1:0] cur_slot;
   logic [7:0]        presc_cnt;
   logic [7:0]        time_cnt;
   logic [7:0]        div_cfg;
   logic [6:0]        wake_cfg;

   aging_thread_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic runnable(input logic [7:0] p);
      return (p != 8'd0) && (p <= 8'(AGE_MAX));
   endfunction

   function automatic logic [1:0] pass_on();
      logic [SLOT_W-1:0] s;
      s = cur_slot;
      for (int k = 0; k < SLOTS; k++) begin
         s = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
         if (runnable(slot_prio[s])) begin
            cur_slot = s;
            return STATUS_OK;
         end
      end
      cur_slot = '0;
      return STATUS_IDLE;
   endfunction

   function automatic rsp_type sched_predict(input req_type ev);
      rsp_type           r;
      logic [7:0]        wp;
      logic [7:0]        top;
      logic [SLOT_W-1:0] best;
      logic              found;
      r.thread = cur_slot;
      r.status = STATUS_OK;
      case (ev.mode)
         MODE_TICK: begin
            wp = (wake_cfg == '0) ? 8'd1 : {1'b0, wake_cfg};
            presc_cnt = (presc_cnt == div_cfg) ? 8'd0 : presc_cnt + 8'd1;
            if (presc_cnt == 8'd0) begin
               time_cnt = time_cnt + 8'd1;
            end
            for (int i = 1; i < SLOTS; i++) begin
               if (runnable(slot_prio[i])) begin
                  if (SLOT_W'(i) == cur_slot) begin
                     slot_prio[i] = 8'd1;
                  end else if (slot_prio[i] < 8'(AGE_MAX)) begin
                     slot_prio[i] = slot_prio[i] + 8'd1;
                  end
               end else if (slot_prio[i] == SLEEP_MARK && wake_at[i] == time_cnt) begin
                  slot_prio[i] = wp;
               end
            end
            top  = '0;
            best = '0;
            for (int i = 1; i < SLOTS; i++) begin
               if (runnable(slot_prio[i]) && slot_prio[i] > top) begin
                  top  = slot_prio[i];
                  best = SLOT_W'(i);
               end
            end
            cur_slot = best;
            r.thread = best;
            r.status = (best == '0) ? STATUS_IDLE : STATUS_OK;
         end
         MODE_CREATE: begin
            found    = 1'b0;
            r.thread = '0;
            r.status = STATUS_NOFREE;
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && slot_prio[i] == 8'd0) begin
                  slot_prio[i] = 8'd1;
                  r.thread     = SLOT_W'(i);
                  r.status     = STATUS_OK;
                  found        = 1'b1;
               end
            end
         end
         MODE_DELAY: begin
            wake_at[cur_slot]   = time_cnt + ev.delay_ticks;
            slot_prio[cur_slot] = SLEEP_MARK;
            r.status = pass_on();
            r.thread = cur_slot;
         end
         MODE_YIELD: begin
            r.status = pass_on();
            r.thread = cur_slot;
         end
         MODE_EXIT: begin
            slot_prio[cur_slot] = 8'd0;
            r.status = pass_on();
            r.thread = cur_slot;
         end
         default: begin
         end
      endcase
      r.time_now = time_cnt;
      return r;
   endfunction

   function automatic void queue_event(input logic [2:0] m, input logic [7:0] n);
      req_type ev;
      ev.mode        = m;
      ev.delay_ticks = n;
      event_queue.push_back(ev);
   endfunction

   // mostly short sleeps so that sleepers wake, with spare modes as noise
   function automatic req_type make_event(input int tick_pct);
      req_type ev;
      int      pick;
      ev.delay_ticks = ($urandom_range(99) < 70) ? 8'($urandom_range(3)) : 8'($urandom);
      if ($urandom_range(99) < tick_pct) begin
         ev.mode = MODE_TICK;
      end else begin
         pick = $urandom_range(40);
         if (pick < 12) begin
            ev.mode = MODE_CREATE;
         end else if (pick < 22) begin
            ev.mode = MODE_DELAY;
         end else if (pick < 30) begin
            ev.mode = MODE_YIELD;
         end else if (pick < 38) begin
            ev.mode = MODE_EXIT;
         end else begin
            ev.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
         end
      end
      return ev;
   endfunction

   task automatic drain();
      while (event_queue.size() != 0 || req_valid || predicted_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TICK_DIVIDE:   div_cfg  = val;
         CSR_WAKE_PRIORITY: wake_cfg = val[6:0];
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(sched_predict(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (event_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_data  <= event_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               $error("unexpected item: thread %0d status %0d time_now %0d",
                      rsp_data.thread, rsp_data.status, rsp_data.time_now);
               errors++;
            end else begin
               want = predicted_rsp.pop_front();
               if (rsp_data.thread !== want.thread) begin
                  $error("thread: expected %0d, got %0d", want.thread, rsp_data.thread);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.time_now !== want.time_now) begin
                  $error("time_now: expected %0d, got %0d", want.time_now, rsp_data.time_now);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
      end
   end

   initial begin
      req_type ev;
      int      ticks_needed;
      int      ticks_added;
      int      n_ev;
      for (int i = 0; i < SLOTS; i++) begin
         slot_prio[i] = '0;
         wake_at[i]   = '0;
      end
      cur_slot  = '0;
      presc_cnt = '0;
      time_cnt  = TIME_RST;
      div_cfg   = TICK_DIVIDE_RST;
      wake_cfg  = WAKE_PRIORITY_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 30;
      rsp_hold_pct = 85;
      // five ticks in all so the prescaler is back at zero afterwards
      queue_event(MODE_TICK, 8'd0);
      queue_event(MODE_YIELD, 8'd0);
      queue_event(MODE_DELAY, 8'd255);
      queue_event(MODE_EXIT, 8'd0);
      repeat (SLOTS + 1) queue_event(MODE_CREATE, 8'd0);
      queue_event(MODE_SPARE_LO, 8'd255);
      queue_event(MODE_SPARE_LO + 3'd1, 8'd0);
      queue_event(MODE_SPARE_HI, 8'd255);
      queue_event(MODE_TICK, 8'd255);
      queue_event(MODE_TICK, 8'd0);
      queue_event(MODE_YIELD, 8'd0);
      queue_event(MODE_DELAY, 8'd1);
      queue_event(MODE_DELAY, 8'd0);
      queue_event(MODE_TICK, 8'd0);
      queue_event(MODE_TICK, 8'd0);
      queue_event(MODE_EXIT, 8'd0);
      queue_event(MODE_YIELD, 8'd0);
      repeat (3) queue_event(MODE_EXIT, 8'd0);
      drain();

      csr_write(CSR_TICK_DIVIDE, 8'd0);
      csr_write(CSR_WAKE_PRIORITY, 8'd127);
      csr_valid <= 1'b0;
      repeat (100) event_queue.push_back(make_event(45));
      drain();

      send_gap_pct = 85;
      rsp_hold_pct = 30;
      csr_write(CSR_TICK_DIVIDE, 8'd255);
      csr_write(CSR_WAKE_PRIORITY, 8'd0);
      csr_write(CSR_SPARE, 8'($urandom));
      csr_valid <= 1'b0;
      queue_event(MODE_TICK, 8'($urandom));
      repeat (150) event_queue.push_back(make_event(70));
      drain();

      // top dropped below the prescaler count, which must run on to its wrap
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      csr_write(CSR_TICK_DIVIDE, 8'($urandom_range(3)));
      csr_write(CSR_WAKE_PRIORITY, 8'd1);
      csr_valid <= 1'b0;
      ticks_needed = 260 - int'(presc_cnt);
      ticks_added  = 0;
      n_ev         = 0;
      while (ticks_added < ticks_needed || n_ev < 40) begin
         ev = make_event(70);
         if (ev.mode == MODE_TICK) begin
            ticks_added++;
         end
         event_queue.push_back(ev);
         n_ev++;
      end
      drain();

      csr_write(CSR_TICK_DIVIDE, 8'($urandom_range(6, 3)));
      csr_write(CSR_WAKE_PRIORITY, 8'($urandom_range(126, 2)));
      csr_valid <= 1'b0;
      repeat (60) event_queue.push_back(make_event(50));
      drain();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("TEST FAILED");
      $finish;
   end

endmodule
